[hdl/rrt_pkg.sv]
// ----------------------------------------------------------------------------
// rrt_pkg
// Shared types and constants of the rectangle region table.
// ----------------------------------------------------------------------------
package rrt_pkg;

    localparam int MAX_REGIONS = 16;
    localparam int COORD_BITS  = 10;
    localparam int SLOT_BITS   = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_BITS    = $clog2(MAX_REGIONS + 1);
    localparam int HANDLE_BITS = 4;
    localparam int STATUS_BITS = 3;

    localparam logic [STATUS_BITS-1:0] ST_ADDED     = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_BOUNDS    = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_MALFORMED = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_OVERLAP   = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_FULL      = 3'd4;
    localparam logic [STATUS_BITS-1:0] ST_REMOVED   = 3'd5;
    localparam logic [STATUS_BITS-1:0] ST_NOTFOUND  = 3'd6;

    localparam logic MODE_ADD    = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    typedef struct packed {
        logic                   mode;
        logic [COORD_BITS-1:0]  left;
        logic [COORD_BITS-1:0]  top;
        logic [COORD_BITS-1:0]  right;
        logic [COORD_BITS-1:0]  bottom;
        logic [HANDLE_BITS-1:0] handle;
    } t_req;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [HANDLE_BITS-1:0] slot;
    } t_rsp;

    typedef struct packed {
        logic [COORD_BITS-1:0] left;
        logic [COORD_BITS-1:0] top;
        logic [COORD_BITS-1:0] right;
        logic [COORD_BITS-1:0] bottom;
    } t_rect;

    typedef struct packed {
        logic                 wr_en;
        logic [SLOT_BITS-1:0] wr_addr;
        logic                 clr_en;
        logic [SLOT_BITS-1:0] clr_addr;
    } t_tbl_ctl;

endpackage

[hdl/rectangle_region_table.sv]
// ----------------------------------------------------------------------------
// rectangle_region_table
// Table of non-overlapping rectangles with add and remove commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; exactly one result
// follows on o_rsp, marked by o_done for one cycle, and must be taken then.
// A remove, or an add rejected as out of bounds or malformed, is answered
// from the check state. An add that passes those checks walks the table one
// slot per cycle through the memory read port and the shared overlap
// comparator: busy stays high until the last slot is compared, or less long
// when an overlap is found early. The result appears in the cycle busy falls.
// Grid registers sit at byte addresses 0 (width) and 4 (height).
module rectangle_region_table
    import rrt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_req        i_req,
    output logic        o_done,
    output t_rsp        o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;

    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(MAX_REGIONS - 1);
    localparam logic [CNT_BITS-1:0]  SLOT_CNT  = CNT_BITS'(MAX_REGIONS);

    logic [1:0]            r_state, n_state;
    t_req                  r_req, n_req;
    logic [COORD_BITS-1:0] r_gw, r_gh;
    logic [CNT_BITS-1:0]   r_idx, n_idx;
    logic                  r_cmp_act, n_cmp_act;
    logic [SLOT_BITS-1:0]  r_cmp_idx, n_cmp_idx;
    logic                  r_free_found, n_free_found;
    logic [SLOT_BITS-1:0]  r_free_slot, n_free_slot;
    logic                  r_done, n_done;
    t_rsp                  r_rsp, n_rsp;

    t_rect                  rd_data;
    t_rect                  req_rect;
    logic [MAX_REGIONS-1:0] valid;
    t_tbl_ctl               ctl;
    logic                   ovl_hit;
    logic                   cur_valid;
    logic                   out_of_bounds;
    logic                   malformed;
    logic [SLOT_BITS-1:0]   h_idx;
    logic                   cfg_wr;

    assign req_rect = '{left: r_req.left, top: r_req.top,
                        right: r_req.right, bottom: r_req.bottom};

    rrt_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (r_idx[SLOT_BITS-1:0]),
        .o_rd_data (rd_data),
        .i_ctl     (ctl),
        .i_wr_data (req_rect),
        .o_valid   (valid)
    );

    rrt_overlap u_overlap (
        .i_a   (req_rect),
        .i_s   (rd_data),
        .o_hit (ovl_hit)
    );

    assign out_of_bounds =
        ({1'b0, r_req.left} > {1'b0, r_gw}) ||
        ({1'b0, r_req.right} > ({1'b0, r_gw} + (COORD_BITS+1)'(1))) ||
        ({1'b0, r_req.top} > {1'b0, r_gh}) ||
        ({1'b0, r_req.bottom} > ({1'b0, r_gh} + (COORD_BITS+1)'(1)));
    assign malformed = (r_req.left > r_req.right) || (r_req.top > r_req.bottom);
    assign h_idx     = SLOT_BITS'(r_req.handle);
    assign cur_valid = valid[r_cmp_idx];

    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_idx        = r_idx;
        n_cmp_act    = r_cmp_act;
        n_cmp_idx    = r_cmp_idx;
        n_free_found = r_free_found;
        n_free_slot  = r_free_slot;
        n_done       = 1'b0;
        n_rsp        = r_rsp;
        ctl          = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req   = i_req;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_idx        = '0;
                n_cmp_act    = 1'b0;
                n_free_found = 1'b0;
                n_rsp.slot   = '0;
                if (r_req.mode == MODE_REMOVE) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                    if ((32'(r_req.handle) < MAX_REGIONS) && valid[h_idx]) begin
                        ctl.clr_en   = 1'b1;
                        ctl.clr_addr = h_idx;
                        n_rsp.status = ST_REMOVED;
                    end else begin
                        n_rsp.status = ST_NOTFOUND;
                    end
                end else if (out_of_bounds) begin
                    n_done       = 1'b1;
                    n_state      = S_IDLE;
                    n_rsp.status = ST_BOUNDS;
                end else if (malformed) begin
                    n_done       = 1'b1;
                    n_state      = S_IDLE;
                    n_rsp.status = ST_MALFORMED;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_idx < SLOT_CNT) begin
                    n_idx     = r_idx + CNT_BITS'(1);
                    n_cmp_act = 1'b1;
                    n_cmp_idx = r_idx[SLOT_BITS-1:0];
                end else begin
                    n_cmp_act = 1'b0;
                end
                if (r_cmp_act) begin
                    if (cur_valid && ovl_hit) begin
                        n_done       = 1'b1;
                        n_state      = S_IDLE;
                        n_rsp.status = ST_OVERLAP;
                        n_rsp.slot   = '0;
                    end else if (r_cmp_idx == LAST_SLOT) begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                        if (r_free_found || !cur_valid) begin
                            ctl.wr_en    = 1'b1;
                            ctl.wr_addr  = r_free_found ? r_free_slot : r_cmp_idx;
                            n_rsp.status = ST_ADDED;
                            n_rsp.slot   = HANDLE_BITS'(ctl.wr_addr);
                        end else begin
                            n_rsp.status = ST_FULL;
                            n_rsp.slot   = '0;
                        end
                    end else if (!r_free_found && !cur_valid) begin
                        n_free_found = 1'b1;
                        n_free_slot  = r_cmp_idx;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_cmp_act    <= 1'b0;
            r_cmp_idx    <= '0;
            r_free_found <= 1'b0;
            r_free_slot  <= '0;
            r_done       <= 1'b0;
            r_gw         <= '0;
            r_gh         <= '0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_cmp_act    <= n_cmp_act;
            r_cmp_idx    <= n_cmp_idx;
            r_free_found <= n_free_found;
            r_free_slot  <= n_free_slot;
            r_done       <= n_done;
            if (cfg_wr && !paddr[2]) begin
                r_gw <= pwdata[COORD_BITS-1:0];
            end
            if (cfg_wr && paddr[2]) begin
                r_gh <= pwdata[COORD_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_rsp <= n_rsp;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;
    assign pready = 1'b1;
    assign prdata = paddr[2] ? {(32-COORD_BITS)'(0), r_gh}
                             : {(32-COORD_BITS)'(0), r_gw};

endmodule

[hdl/rrt_overlap.sv]
// ----------------------------------------------------------------------------
// rrt_overlap
// Shared strict-overlap comparator; touching edges are not an overlap.
// ----------------------------------------------------------------------------
module rrt_overlap
    import rrt_pkg::*;
(
    input  t_rect i_a,
    input  t_rect i_s,
    output logic  o_hit
);

    logic apart_x;
    logic apart_y;

    assign apart_x = (i_a.left >= i_s.right) || (i_s.left >= i_a.right);
    assign apart_y = (i_a.top >= i_s.bottom) || (i_s.top >= i_a.bottom);
    assign o_hit   = !apart_x && !apart_y;

endmodule

[hdl/rrt_store.sv]
// ----------------------------------------------------------------------------
// rrt_store
// Rectangle memory with registered read and per-slot valid flags.
// ----------------------------------------------------------------------------
module rrt_store
    import rrt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [SLOT_BITS-1:0]   i_rd_addr,
    output t_rect                  o_rd_data,
    input  t_tbl_ctl               i_ctl,
    input  t_rect                  i_wr_data,
    output logic [MAX_REGIONS-1:0] o_valid
);

    t_rect r_mem [MAX_REGIONS];
    t_rect r_rd_data;
    logic [MAX_REGIONS-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_ctl.wr_en) begin
                r_valid[i_ctl.wr_addr] <= 1'b1;
            end
            if (i_ctl.clr_en) begin
                r_valid[i_ctl.clr_addr] <= 1'b0;
            end
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_valid   = r_valid;

endmodule

[hdl/rrt_checker.sv]
// ----------------------------------------------------------------------------
// rrt_checker
// Port-level checks of the rectangle region table, bound to the top level.
// ----------------------------------------------------------------------------
module rrt_checker
    import rrt_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done,
    input t_rsp o_rsp
);

    // accepted transaction makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted transaction");

    // a result comes in the cycle busy falls
    a_fall_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("busy fell without a result");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (!busy && !$past(o_done)))
        else $error("result strobe while busy or repeated");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_rsp.status <= ST_NOTFOUND))
        else $error("undefined status code");

    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_rsp.status != ST_ADDED)) |-> (o_rsp.slot == '0))
        else $error("slot nonzero on a result that is not an add");

endmodule

bind rectangle_region_table rrt_checker u_rrt_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);
